FILE: rtl/dhfk_pkg.sv
package dhfk_pkg;

    localparam int CordicIterations = 24;
    localparam int IterW = $clog2(CordicIterations + 1);

    // A Q.30 angle from any input stays below 2*pi * 2^10 in magnitude, so ten
    // compare and subtract steps with 2*pi * 2^9 down to 2*pi bring it into (-2*pi, 2*pi).
    localparam int WrapSteps = 10;

    localparam logic signed [35:0] PiQ30     = 36'sd3373259426;
    localparam logic signed [35:0] HalfPiQ30 = 36'sd1686629713;
    localparam logic signed [35:0] TwoPiQ30  = 36'sd6746518852;
    localparam logic signed [35:0] GainQ30   = 36'sd652032874;
    localparam logic signed [25:0] Deg2RadQ30 = 26'sd18740330;
    localparam logic signed [24:0] OneQ22    = 25'sd4194304;

    typedef struct packed {
        logic signed [23:0] joint_angle;
        logic signed [23:0] angle_offset;
        logic signed [23:0] link_length;
        logic signed [23:0] link_twist;
        logic signed [23:0] link_offset;
        logic               last_link;
    } link_t;

    typedef struct packed {
        logic signed [23:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
        logic signed [31:0] px, py, pz;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_THETA,
        ST_WRAP,
        ST_REDUCE,
        ST_CORDIC,
        ST_FINISH,
        ST_LINK,
        ST_LINK2,
        ST_ROT,
        ST_TRANS,
        ST_UPDATE,
        ST_EMIT
    } state_t;

    function automatic logic signed [35:0] atan_q30(input logic [4:0] i);
        logic signed [35:0] v;
        begin
            v = '0;
            case (i)
                5'd0: v = 36'sd843314856;
                5'd1: v = 36'sd497837829;
                5'd2: v = 36'sd263043836;
                5'd3: v = 36'sd133525158;
                5'd4: v = 36'sd67021686;
                5'd5: v = 36'sd33543515;
                5'd6: v = 36'sd16775850;
                5'd7: v = 36'sd8388437;
                5'd8: v = 36'sd4194282;
                5'd9: v = 36'sd2097149;
                5'd10: v = 36'sd1048575;
                5'd11: v = 36'sd524287;
                5'd12: v = 36'sd262143;
                5'd13: v = 36'sd131071;
                5'd14: v = 36'sd65535;
                5'd15: v = 36'sd32767;
                5'd16: v = 36'sd16383;
                5'd17: v = 36'sd8191;
                5'd18: v = 36'sd4095;
                5'd19: v = 36'sd2047;
                5'd20: v = 36'sd1023;
                5'd21: v = 36'sd511;
                5'd22: v = 36'sd255;
                5'd23: v = 36'sd127;
                5'd24: v = 36'sd63;
                5'd25: v = 36'sd31;
                5'd26: v = 36'sd15;
                5'd27: v = 36'sd7;
                5'd28: v = 36'sd3;
                5'd29: v = 36'sd1;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

    function automatic logic signed [23:0] clamp22(input logic signed [63:0] x);
        logic signed [63:0] r;
        begin
            r = x;
            if (x > 64'sd4194304) r = 64'sd4194304;
            if (x < -64'sd4194304) r = -64'sd4194304;
            return r[23:0];
        end
    endfunction

    function automatic logic signed [63:0] rnd22(input logic signed [63:0] x);
        logic signed [63:0] t;
        begin
            t = x + 64'sd2097152;
            return t >>> 22;
        end
    endfunction

endpackage

FILE: rtl/dh_forward_kinematics_chain.sv
// Modified-DH forward kinematics: push one link per transaction, last_link closes the chain
// and one pose result appears. Each link runs through the single shared iterative CORDIC, which
// computes theta and then alpha after a ten-step angle wrap; a two-entry link queue decouples
// the input from the compute engine. The next chain runs while a pose waits, but its last link
// holds until the waiting pose is popped.
module dh_forward_kinematics_chain (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [23:0] joint_angle,
    input  logic signed [23:0] angle_offset,
    input  logic signed [23:0] link_length,
    input  logic signed [23:0] link_twist,
    input  logic signed [23:0] link_offset,
    input  logic               last_link,
    output logic               empty,
    input  logic               pop,
    output logic signed [23:0] rot_00, rot_01, rot_02,
    output logic signed [23:0] rot_10, rot_11, rot_12,
    output logic signed [23:0] rot_20, rot_21, rot_22,
    output logic signed [31:0] pos_x, pos_y, pos_z,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_data
);
    import dhfk_pkg::*;

    logic    deg_reg, q_valid, q_take, res_valid, busy;
    link_t   q_data;
    result_t res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) deg_reg <= 1'b0;
        else if (cfg_valid && cfg_ready) deg_reg <= cfg_data;
    end

    dhfk_front u_front (
        .clk, .rst_n, .push, .full, .joint_angle, .angle_offset, .link_length,
        .link_twist, .link_offset, .last_link, .q_valid, .q_data, .q_take
    );

    dhfk_back u_back (
        .clk, .rst_n, .deg_mode(deg_reg), .q_valid, .q_data, .q_take,
        .res_valid, .res_data(res), .res_take(pop), .busy
    );

    assign empty = !res_valid;
    assign rot_00 = res.r00; assign rot_01 = res.r01; assign rot_02 = res.r02;
    assign rot_10 = res.r10; assign rot_11 = res.r11; assign rot_12 = res.r12;
    assign rot_20 = res.r20; assign rot_21 = res.r21; assign rot_22 = res.r22;
    assign pos_x = res.px; assign pos_y = res.py; assign pos_z = res.pz;

`ifndef ASSERT_OFF
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> busy) else $error("result without busy engine");
    a_pop_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty) else $error("result dropped");
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |=> deg_reg == $past(cfg_data)) else $error("config lost");
`endif
endmodule

FILE: rtl/dhfk_front.sv
module dhfk_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  logic signed [23:0] joint_angle,
    input  logic signed [23:0] angle_offset,
    input  logic signed [23:0] link_length,
    input  logic signed [23:0] link_twist,
    input  logic signed [23:0] link_offset,
    input  logic           last_link,
    output logic           q_valid,
    output dhfk_pkg::link_t q_data,
    input  logic           q_take
);
    import dhfk_pkg::*;

    link_t mem_reg [2];
    logic  wp_reg, rp_reg, wp_next, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic  do_push, do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data  = mem_reg[rp_reg];
    assign do_push = push && !full;
    assign do_pop  = q_take && q_valid;

    always_comb
    begin
        wp_next  = wp_reg ^ do_push;
        rp_next  = rp_reg ^ do_pop;
        cnt_next = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wp_reg] <= '{joint_angle, angle_offset, link_length,
                                 link_twist, link_offset, last_link};
        end
    end

`ifndef ASSERT_OFF
    a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("queue count out of range");
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> q_valid) else $error("full queue reads as empty");
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("queue count did not advance");
`endif
endmodule

FILE: rtl/dhfk_back.sv
module dhfk_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            deg_mode,
    input  logic            q_valid,
    input  dhfk_pkg::link_t q_data,
    output logic            q_take,
    output logic            res_valid,
    output dhfk_pkg::result_t res_data,
    input  logic            res_take,
    output logic            busy
);
    import dhfk_pkg::*;

    state_t state_reg, state_next;
    link_t  lk_reg;
    logic signed [43:0] ang_reg;
    logic signed [35:0] cx_reg, cy_reg, cr_reg;
    logic   neg_reg, pass_reg;
    logic [IterW-1:0] it_reg;
    logic [3:0] wk_reg;
    logic signed [23:0] st_reg, ct_reg, sa_reg, ca_reg;
    logic signed [23:0] lr_reg [9];
    logic signed [31:0] lt_reg [3];
    logic signed [23:0] ar_reg [9];
    logic signed [31:0] at_reg [3];
    logic signed [23:0] nr_reg [9];
    logic [1:0] row_reg;
    logic   rv_reg;
    result_t out_reg;

    logic signed [49:0] deg_prod;
    logic signed [43:0] wstep, wrapped, red;
    logic signed [35:0] red2;
    logic signed [35:0] xs, ys;
    logic signed [23:0] cres, sres;
    logic signed [47:0] pm [3];
    logic signed [63:0] tsum;
    logic signed [63:0] rsum [3];
    logic   emit_go;

    assign busy = (state_reg != ST_IDLE) || rv_reg;
    assign q_take = (state_reg == ST_IDLE) && q_valid;
    assign res_valid = rv_reg;
    assign res_data = out_reg;
    assign emit_go = !rv_reg || res_take;

    always_comb
    begin
        deg_prod = lk_reg.joint_angle * Deg2RadQ30;
        wstep = 44'(TwoPiQ30) <<< wk_reg;
        wrapped = ang_reg;
        if (!ang_reg[43])
        begin
            if (ang_reg >= wstep) wrapped = ang_reg - wstep;
        end
        else if (ang_reg <= -wstep) wrapped = ang_reg + wstep;
        red = ang_reg;
        if (red < 0) red = red + 44'(TwoPiQ30);
        if (red > 44'(PiQ30)) red = red - 44'(TwoPiQ30);
        red2 = 36'(red);
        if (red > 44'(HalfPiQ30)) red2 = 36'(red - 44'(PiQ30));
        else if (red < -44'(HalfPiQ30)) red2 = 36'(red + 44'(PiQ30));
        xs = cx_reg >>> it_reg;
        ys = cy_reg >>> it_reg;
        cres = clamp22(64'((neg_reg ? -cx_reg : cx_reg) + 36'sd128) >>> 8);
        sres = clamp22(64'((neg_reg ? -cy_reg : cy_reg) + 36'sd128) >>> 8);
        for (int k = 0; k < 3; k++)
            pm[k] = 48'(ar_reg[row_reg * 3 + k]) * 48'(lt_reg[k]);
        tsum = rnd22(64'(pm[0]) + 64'(pm[1]) + 64'(pm[2])) + 64'(at_reg[row_reg]);
        for (int c = 0; c < 3; c++)
            rsum[c] = rnd22(64'(48'(ar_reg[row_reg * 3]) * 48'(lr_reg[c]))
                          + 64'(48'(ar_reg[row_reg * 3 + 1]) * 48'(lr_reg[3 + c]))
                          + 64'(48'(ar_reg[row_reg * 3 + 2]) * 48'(lr_reg[6 + c])));
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (q_take) state_next = ST_THETA;
            ST_THETA:  state_next = ST_WRAP;
            ST_WRAP:   if (wk_reg == 4'd0) state_next = ST_REDUCE;
            ST_REDUCE: state_next = ST_CORDIC;
            ST_CORDIC: if (it_reg == IterW'(CordicIterations - 1)) state_next = ST_FINISH;
            ST_FINISH: state_next = pass_reg ? ST_LINK : ST_WRAP;
            ST_LINK:   state_next = ST_LINK2;
            ST_LINK2:  state_next = ST_TRANS;
            ST_TRANS:  if (row_reg == 2'd2) state_next = ST_ROT;
            ST_ROT:    if (row_reg == 2'd2) state_next = ST_UPDATE;
            ST_UPDATE: state_next = lk_reg.last_link ? ST_EMIT : ST_IDLE;
            ST_EMIT:   if (emit_go) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rv_reg    <= 1'b0;
            for (int k = 0; k < 9; k++) ar_reg[k] <= (k % 4 == 0) ? 24'(OneQ22) : '0;
            for (int k = 0; k < 3; k++) at_reg[k] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (res_take && rv_reg) rv_reg <= 1'b0;
            if (state_reg == ST_UPDATE)
                for (int k = 0; k < 9; k++) ar_reg[k] <= nr_reg[k];
            if (state_reg == ST_TRANS)
                at_reg[row_reg] <= (tsum > 64'sd2147483647) ? 32'h7fffffff :
                                   (tsum < -64'sd2147483648) ? 32'h80000000 : tsum[31:0];
            if (state_reg == ST_EMIT && emit_go)
            begin
                rv_reg <= 1'b1;
                for (int k = 0; k < 9; k++) ar_reg[k] <= (k % 4 == 0) ? 24'(OneQ22) : '0;
                for (int k = 0; k < 3; k++) at_reg[k] <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                lk_reg   <= q_data;
                pass_reg <= 1'b0;
            end
            ST_THETA:
            begin
                if (deg_mode)
                    ang_reg <= 44'((deg_prod + 50'sd2048) >>> 12)
                               + (44'(lk_reg.angle_offset) <<< 18);
                else
                    ang_reg <= (44'(lk_reg.joint_angle) <<< 18)
                               + (44'(lk_reg.angle_offset) <<< 18);
                wk_reg <= 4'(WrapSteps - 1);
            end
            ST_WRAP:
            begin
                ang_reg <= wrapped;
                wk_reg  <= wk_reg - 4'd1;
            end
            ST_REDUCE:
            begin
                cr_reg  <= red2;
                neg_reg <= (red > 44'(HalfPiQ30)) || (red < -44'(HalfPiQ30));
                cx_reg  <= GainQ30;
                cy_reg  <= '0;
                it_reg  <= '0;
            end
            ST_CORDIC:
            begin
                if (cr_reg >= 0)
                begin
                    cx_reg <= cx_reg - ys;
                    cy_reg <= cy_reg + xs;
                    cr_reg <= cr_reg - atan_q30(5'(it_reg));
                end
                else
                begin
                    cx_reg <= cx_reg + ys;
                    cy_reg <= cy_reg - xs;
                    cr_reg <= cr_reg + atan_q30(5'(it_reg));
                end
                it_reg <= it_reg + 1'b1;
            end
            ST_FINISH:
            begin
                if (!pass_reg)
                begin
                    st_reg   <= sres;
                    ct_reg   <= cres;
                    ang_reg  <= 44'(lk_reg.link_twist) <<< 18;
                    wk_reg   <= 4'(WrapSteps - 1);
                    pass_reg <= 1'b1;
                end
                else
                begin
                    sa_reg <= sres;
                    ca_reg <= cres;
                end
            end
            ST_LINK:
            begin
                lr_reg[0] <= ct_reg;
                lr_reg[1] <= -st_reg;
                lr_reg[2] <= '0;
                lr_reg[3] <= clamp22(rnd22(64'(48'(st_reg) * 48'(ca_reg))));
                lr_reg[4] <= clamp22(rnd22(64'(48'(ct_reg) * 48'(ca_reg))));
                lr_reg[5] <= -sa_reg;
                lr_reg[6] <= clamp22(rnd22(64'(48'(st_reg) * 48'(sa_reg))));
                lr_reg[7] <= clamp22(rnd22(64'(48'(ct_reg) * 48'(sa_reg))));
                lr_reg[8] <= ca_reg;
                lt_reg[0] <= 32'(lk_reg.link_length);
                row_reg   <= 2'd0;
            end
            ST_LINK2:
            begin
                lt_reg[1] <= 32'(rnd22(-64'(48'(lk_reg.link_offset) * 48'(sa_reg))));
                lt_reg[2] <= 32'(rnd22(64'(48'(lk_reg.link_offset) * 48'(ca_reg))));
            end
            ST_TRANS:
                row_reg <= (row_reg == 2'd2) ? 2'd0 : row_reg + 2'd1;
            ST_ROT:
            begin
                for (int c = 0; c < 3; c++) nr_reg[row_reg * 3 + c] <= clamp22(rsum[c]);
                row_reg <= row_reg + 2'd1;
            end
            ST_EMIT:
                if (emit_go)
                    out_reg <= '{ar_reg[0], ar_reg[1], ar_reg[2], ar_reg[3], ar_reg[4],
                                 ar_reg[5], ar_reg[6], ar_reg[7], ar_reg[8],
                                 at_reg[0], at_reg[1], at_reg[2]};
            default: ;
        endcase
    end

`ifndef ASSERT_OFF
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_take |=> state_reg == ST_THETA) else $error("transaction not started");
    a_emit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |=> rv_reg) else $error("result not posted");
    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && !emit_go) |=> state_reg == ST_EMIT)
        else $error("pose overwrote a waiting result");
`endif
endmodule

FILE: dv/dh_forward_kinematics_chain_tb.sv
`timescale 1ns / 100ps

module dh_forward_kinematics_chain_tb;
    import dhfk_pkg::*;

    localparam logic [63:0] Deg2Rad = 64'd18740330;
    localparam longint OneQ = 4194304;
    localparam longint TwoPi = 64'sd6746518852;
    localparam longint Pi = 64'sd3373259426;
    localparam longint HalfPi = 64'sd1686629713;
    localparam longint Gain = 64'sd652032874;
    localparam int WatchdogLimit = 20000;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    logic signed [23:0] joint_angle, angle_offset, link_length, link_twist, link_offset;
    logic last_link;
    logic empty;
    logic pop;
    logic signed [23:0] rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_21, rot_22;
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic cfg_valid;
    logic cfg_ready;
    logic cfg_data;

    longint pose_rot[9];
    longint pose_pos[3];
    bit degrees_mode;
    result_t pending_poses[$];
    int mismatches = 0;
    int poses_checked = 0;
    int links_sent;
    int idle_cycles = 0;
    bit steady_mode;
    bit timed_out = 0;

    dh_forward_kinematics_chain uut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .joint_angle(joint_angle), .angle_offset(angle_offset),
        .link_length(link_length), .link_twist(link_twist),
        .link_offset(link_offset), .last_link(last_link),
        .empty(empty), .pop(pop),
        .rot_00(rot_00), .rot_01(rot_01), .rot_02(rot_02),
        .rot_10(rot_10), .rot_11(rot_11), .rot_12(rot_12),
        .rot_20(rot_20), .rot_21(rot_21), .rot_22(rot_22),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic longint round_shift(longint x, int n);
        return (x + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint limit(longint x, longint lo, longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function automatic longint table_atan(int i);
        longint tab[32] = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
            16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
            65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31,
            15, 7, 3, 1, 0, 0};
        return tab[i];
    endfunction

    task automatic cordic_sincos(input longint ang, output longint s, output longint c);
        longint r, x, y, t;
        bit flip;
        r = ang % TwoPi;
        x = Gain;
        y = 0;
        flip = 0;
        if (r < 0) r += TwoPi;
        if (r > Pi) r -= TwoPi;
        if (r > HalfPi)
        begin
            r -= Pi;
            flip = 1;
        end
        else if (r < -HalfPi)
        begin
            r += Pi;
            flip = 1;
        end
        for (int i = 0; i < CordicIterations && i < 32; i++)
        begin
            if (r >= 0)
            begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                r -= table_atan(i);
            end
            else
            begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                r += table_atan(i);
            end
            x = t;
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        c = limit(round_shift(x, 8), -OneQ, OneQ);
        s = limit(round_shift(y, 8), -OneQ, OneQ);
    endtask

    function automatic longint qmul(longint a, longint b);
        return limit(round_shift(a * b, 22), -OneQ, OneQ);
    endfunction

    task automatic clear_pose();
        for (int k = 0; k < 9; k++) pose_rot[k] = (k % 4 == 0) ? OneQ : 0;
        for (int k = 0; k < 3; k++) pose_pos[k] = 0;
    endtask

    task automatic chain_link(input link_t ln);
        longint theta, st, ct, sa, ca, sum;
        longint lk[9];
        longint lt[3];
        longint nr[9];
        result_t pose;
        if (degrees_mode)
            theta = round_shift(longint'(ln.joint_angle) * longint'(Deg2Rad), 12);
        else
            theta = longint'(ln.joint_angle) * (64'sd1 <<< 18);
        theta += longint'(ln.angle_offset) * (64'sd1 <<< 18);
        cordic_sincos(theta, st, ct);
        cordic_sincos(longint'(ln.link_twist) * (64'sd1 <<< 18), sa, ca);
        lk[0] = ct; lk[1] = -st; lk[2] = 0;
        lk[3] = qmul(st, ca); lk[4] = qmul(ct, ca); lk[5] = -sa;
        lk[6] = qmul(st, sa); lk[7] = qmul(ct, sa); lk[8] = ca;
        lt[0] = ln.link_length;
        lt[1] = round_shift(-longint'(ln.link_offset) * sa, 22);
        lt[2] = round_shift(longint'(ln.link_offset) * ca, 22);
        for (int r = 0; r < 3; r++)
        begin
            sum = 0;
            for (int k = 0; k < 3; k++) sum += pose_rot[r * 3 + k] * lt[k];
            sum = round_shift(sum, 22) + pose_pos[r];
            pose_pos[r] = limit(sum, -64'sd2147483648, 64'sd2147483647);
        end
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
            begin
                sum = 0;
                for (int k = 0; k < 3; k++) sum += pose_rot[r * 3 + k] * lk[k * 3 + c];
                nr[r * 3 + c] = limit(round_shift(sum, 22), -OneQ, OneQ);
            end
        for (int k = 0; k < 9; k++) pose_rot[k] = nr[k];
        if (ln.last_link)
        begin
            pose.r00 = 24'(pose_rot[0]); pose.r01 = 24'(pose_rot[1]);
            pose.r02 = 24'(pose_rot[2]); pose.r10 = 24'(pose_rot[3]);
            pose.r11 = 24'(pose_rot[4]); pose.r12 = 24'(pose_rot[5]);
            pose.r20 = 24'(pose_rot[6]); pose.r21 = 24'(pose_rot[7]);
            pose.r22 = 24'(pose_rot[8]);
            pose.px = 32'(pose_pos[0]); pose.py = 32'(pose_pos[1]);
            pose.pz = 32'(pose_pos[2]);
            pending_poses.push_back(pose);
            clear_pose();
        end
    endtask

    function automatic bit idle_now();
        return !steady_mode && ($urandom_range(99) < 38);
    endfunction

    task automatic send_link(input link_t ln);
        while (idle_now())
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        joint_angle <= ln.joint_angle;
        angle_offset <= ln.angle_offset;
        link_length <= ln.link_length;
        link_twist <= ln.link_twist;
        link_offset <= ln.link_offset;
        last_link <= ln.last_link;
        @(posedge clk);
        while (full) @(posedge clk);
        chain_link(ln);
        links_sent++;
    endtask

    task automatic drain();
        push <= 1'b0;
        while (pending_poses.size() != 0 && !timed_out) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic set_units(input bit deg);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= deg;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        degrees_mode = deg;
    endtask

    function automatic link_t make_link(logic signed [23:0] j, logic signed [23:0] o,
        logic signed [23:0] a, logic signed [23:0] t, logic signed [23:0] d, bit last);
        link_t ln;
        ln.joint_angle = j; ln.angle_offset = o; ln.link_length = a;
        ln.link_twist = t; ln.link_offset = d; ln.last_link = last;
        return ln;
    endfunction

    function automatic logic signed [23:0] pick_value();
        case ($urandom_range(4))
            0: return 24'($urandom);
            1: return $urandom_range(1) ? 24'sh7fffff : 24'sh800000;
            default: return $signed(24'($urandom_range(32767))) - 24'sd16384;
        endcase
    endfunction

    task automatic test_directed();
        send_link(make_link(0, 0, 0, 0, 0, 1));
        send_link(make_link(24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 1));
        send_link(make_link(24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000, 1));
        send_link(make_link(6434, 0, 4096, 6434, 8192, 0));
        send_link(make_link(-6434, 12868, 24'sh7fffff, -6434, 24'sh7fffff, 0));
        send_link(make_link(12868, -12868, 24'sh7fffff, 0, 24'sh7fffff, 0));
        send_link(make_link(0, 0, 24'sh7fffff, 0, 24'sh7fffff, 1));
        for (int i = 0; i < 8; i++)
            send_link(make_link(0, 0, 24'sh7fffff, 0, 24'sh7fffff, i == 7));
        send_link(make_link(12868, 0, 100, 12868, 200, 1));
        send_link(make_link(-12868, 0, -100, -12868, -200, 1));
        send_link(make_link(24'sh555555, 24'shaaaaaa, 24'sh555555, 24'shaaaaaa, 24'sh555555, 1));
    endtask

    task automatic test_degrees();
        set_units(1'b1);
        send_link(make_link(90 * 4096, 0, 4096, 0, 0, 0));
        send_link(make_link(-180 * 4096, 0, 4096, 90 * 4096, 4096, 1));
        send_link(make_link(24'sh7fffff, 24'sh800000, 0, 0, 0, 1));
        send_link(make_link(24'sh800000, 24'sh7fffff, 0, 0, 0, 1));
    endtask

    task automatic test_random_chains(input int count);
        int left;
        int len;
        left = count;
        while (left > 0)
        begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len && left > 0; i++)
            begin
                send_link(make_link(pick_value(), pick_value(), pick_value(), pick_value(),
                    pick_value(), i == len - 1 || $urandom_range(15) == 0));
                left--;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (pending_poses.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected pose transaction");
                end
                else
                begin
                    result_t want;
                    result_t got;
                    want = pending_poses.pop_front();
                    got = '{rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
                        rot_20, rot_21, rot_22, pos_x, pos_y, pos_z};
                    poses_checked++;
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("pose %0d: expected %h actual %h", poses_checked,
                                want, got);
                    end
                end
            end
            pop <= !idle_now();
        end
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WatchdogLimit && !timed_out)
        begin
            timed_out = 1;
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        joint_angle = '0;
        angle_offset = '0;
        link_length = '0;
        link_twist = '0;
        link_offset = '0;
        last_link = 1'b0;
        degrees_mode = 0;
        steady_mode = 0;
        links_sent = 0;
        clear_pose();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_units(1'b0);
        test_directed();
        test_degrees();
        test_random_chains(200);
        set_units(1'b0);
        test_random_chains(200);
        steady_mode = 1;
        test_random_chains(100);
        steady_mode = 0;
        set_units(1'b1);
        test_random_chains(100);
        drain();
        $display("Sent %0d links and checked %0d poses in radian and degree modes.",
            links_sent, poses_checked);
        if (mismatches == 0 && pending_poses.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

FILE: dh_forward_kinematics_chain.f
rtl/dhfk_pkg.sv
rtl/dhfk_front.sv
rtl/dhfk_back.sv
rtl/dh_forward_kinematics_chain.sv
dv/dh_forward_kinematics_chain_tb.sv
